[src/biquad_iir_filter_assert.svh]
// assertion macros used by the biquad filter top level
`ifndef BIQUAD_IIR_FILTER_ASSERT_SVH
`define BIQUAD_IIR_FILTER_ASSERT_SVH

// condition checked in the same cycle as the trigger
`define BQ_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("biquad assertion failed");

// condition checked in the cycle after the trigger
`define BQ_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("biquad assertion failed");

`endif

[src/bq_pkg.sv]
// types, constants, microcode table and rounding for the biquad filter
`timescale 1ns / 1ps
`default_nettype none

package bq_pkg;

  localparam int SAMPLE_W  = 24;
  localparam int COEF_W    = 18;
  localparam int FRAC_BITS = 14;
  localparam int PROD_W    = SAMPLE_W + COEF_W;
  // five products summed, plus headroom
  localparam int ACC_W     = PROD_W + 3;
  localparam int RND_W     = ACC_W + 1;
  localparam int SHR_W     = RND_W - FRAC_BITS;
  localparam int IDX_W     = 3;
  localparam int PC_W      = 4;

  localparam logic signed [COEF_W-1:0] COEF_ONE = COEF_W'(1) << FRAC_BITS;
  localparam logic signed [COEF_W-1:0] COEF_ZERO = '0;
  localparam logic signed [RND_W-1:0] ROUND_HALF = RND_W'(1) << (FRAC_BITS - 1);
  localparam logic signed [SAMPLE_W-1:0] SAT_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
  localparam logic signed [SAMPLE_W-1:0] SAT_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

  // configuration register indexes
  localparam logic [IDX_W-1:0] REG_B0   = IDX_W'(0);
  localparam logic [IDX_W-1:0] REG_B1   = IDX_W'(1);
  localparam logic [IDX_W-1:0] REG_B2   = IDX_W'(2);
  localparam logic [IDX_W-1:0] REG_A1   = IDX_W'(3);
  localparam logic [IDX_W-1:0] REG_A2   = IDX_W'(4);
  localparam logic [IDX_W-1:0] REG_GAIN = IDX_W'(5);

  // program addresses
  localparam logic [PC_W-1:0] STEP_IDLE  = PC_W'(0);
  localparam logic [PC_W-1:0] STEP_FIRST = PC_W'(1);
  localparam logic [PC_W-1:0] STEP_LAST  = PC_W'(9);

  // which coefficient and which sample feed the multiplier
  typedef enum logic [2:0] {
    TERM_GAIN,
    TERM_B0,
    TERM_B1,
    TERM_B2,
    TERM_A1,
    TERM_A2
  } term_t;

  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_LOAD,
    ACC_ADD,
    ACC_SUB
  } acc_op_t;

  typedef enum logic [1:0] {
    JMP_NEXT,     // fall through
    JMP_WAIT_IN,  // stay until an item is taken
    JMP_DONE      // back to idle once the output register is free
  } jmp_t;

  typedef struct packed {
    term_t   term;
    acc_op_t acc_op;
    logic    xs_ld;
    logic    y_ld;
    jmp_t    jmp;
  } ucode_t;

  typedef struct packed {
    logic    load_in;
    logic    clear_hist;
    term_t   term;
    acc_op_t acc_op;
    logic    xs_ld;
    logic    y_ld;
  } dp_ctl_t;

  typedef struct packed {
    logic signed [COEF_W-1:0] b0;
    logic signed [COEF_W-1:0] b1;
    logic signed [COEF_W-1:0] b2;
    logic signed [COEF_W-1:0] a1;
    logic signed [COEF_W-1:0] a2;
    logic signed [COEF_W-1:0] gain;
  } coef_set_t;

  // microcode rom: product registered one step, accumulated the next
  function automatic ucode_t ucode(input logic [PC_W-1:0] pc);
    ucode_t w;
    w = '{term: TERM_GAIN, acc_op: ACC_HOLD, xs_ld: 1'b0, y_ld: 1'b0, jmp: JMP_NEXT};
    case (pc)
      PC_W'(0): w.jmp    = JMP_WAIT_IN;
      PC_W'(1): w.term   = TERM_GAIN;
      PC_W'(2): w.xs_ld  = 1'b1;
      PC_W'(3): w.term   = TERM_B0;
      PC_W'(4): begin
        w.term   = TERM_B1;
        w.acc_op = ACC_LOAD;
      end
      PC_W'(5): begin
        w.term   = TERM_B2;
        w.acc_op = ACC_ADD;
      end
      PC_W'(6): begin
        w.term   = TERM_A1;
        w.acc_op = ACC_ADD;
      end
      PC_W'(7): begin
        w.term   = TERM_A2;
        w.acc_op = ACC_SUB;
      end
      PC_W'(8): w.acc_op = ACC_SUB;
      PC_W'(9): begin
        w.y_ld = 1'b1;
        w.jmp  = JMP_DONE;
      end
      default: w.jmp = JMP_DONE;
    endcase
    return w;
  endfunction

  // round half up, drop fraction bits, clamp to sample range
  function automatic logic signed [SAMPLE_W-1:0] round_sat(
    input logic signed [ACC_W-1:0] v
  );
    logic signed [RND_W-1:0] t;
    logic signed [SHR_W-1:0] r;
    t = RND_W'(v) + ROUND_HALF;
    r = t[RND_W-1:FRAC_BITS];
    if (r > SHR_W'(SAT_MAX)) begin
      return SAT_MAX;
    end else if (r < SHR_W'(SAT_MIN)) begin
      return SAT_MIN;
    end
    return SAMPLE_W'(r);
  endfunction

endpackage

`default_nettype wire

[src/bq_datapath.sv]
// shared multiplier, accumulator and sample history of the biquad filter
`timescale 1ns / 1ps
`default_nettype none

module bq_datapath (
  input  wire                                  clk,
  input  wire                                  rst_n,
  input  wire bq_pkg::dp_ctl_t                 ctl,
  input  wire bq_pkg::coef_set_t               coefs,
  input  wire logic signed [bq_pkg::SAMPLE_W-1:0] sample_in,
  output logic signed [bq_pkg::SAMPLE_W-1:0]   sample_out
);

  logic signed [bq_pkg::SAMPLE_W-1:0] x_r, xs_r;
  logic signed [bq_pkg::SAMPLE_W-1:0] x1_r, x1_nxt, x2_r, x2_nxt;
  logic signed [bq_pkg::SAMPLE_W-1:0] y1_r, y1_nxt, y2_r, y2_nxt;
  logic signed [bq_pkg::SAMPLE_W-1:0] out_r, y_new;
  logic signed [bq_pkg::PROD_W-1:0]   prod_r, prod_nxt;
  logic signed [bq_pkg::ACC_W-1:0]    acc_r, acc_nxt;
  logic signed [bq_pkg::COEF_W-1:0]   coef_sel;
  logic signed [bq_pkg::SAMPLE_W-1:0] data_sel;

  always_comb begin
    case (ctl.term)
      bq_pkg::TERM_GAIN: begin
        coef_sel = coefs.gain;
        data_sel = x_r;
      end
      bq_pkg::TERM_B0: begin
        coef_sel = coefs.b0;
        data_sel = xs_r;
      end
      bq_pkg::TERM_B1: begin
        coef_sel = coefs.b1;
        data_sel = x1_r;
      end
      bq_pkg::TERM_B2: begin
        coef_sel = coefs.b2;
        data_sel = x2_r;
      end
      bq_pkg::TERM_A1: begin
        coef_sel = coefs.a1;
        data_sel = y1_r;
      end
      bq_pkg::TERM_A2: begin
        coef_sel = coefs.a2;
        data_sel = y2_r;
      end
      default: begin
        coef_sel = coefs.gain;
        data_sel = x_r;
      end
    endcase
  end

  assign prod_nxt = bq_pkg::PROD_W'(coef_sel) * bq_pkg::PROD_W'(data_sel);

  always_comb begin
    case (ctl.acc_op)
      bq_pkg::ACC_LOAD: acc_nxt = bq_pkg::ACC_W'(prod_r);
      bq_pkg::ACC_ADD:  acc_nxt = acc_r + bq_pkg::ACC_W'(prod_r);
      bq_pkg::ACC_SUB:  acc_nxt = acc_r - bq_pkg::ACC_W'(prod_r);
      default:          acc_nxt = acc_r;
    endcase
  end

  assign y_new = bq_pkg::round_sat(acc_r);

  // history: cleared on a flagged item, shifted when a result is posted
  always_comb begin
    x1_nxt = x1_r;
    x2_nxt = x2_r;
    y1_nxt = y1_r;
    y2_nxt = y2_r;
    if (ctl.load_in && ctl.clear_hist) begin
      x1_nxt = '0;
      x2_nxt = '0;
      y1_nxt = '0;
      y2_nxt = '0;
    end else if (ctl.y_ld) begin
      x1_nxt = xs_r;
      x2_nxt = x1_r;
      y1_nxt = y_new;
      y2_nxt = y1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x1_r <= '0;
      x2_r <= '0;
      y1_r <= '0;
      y2_r <= '0;
    end else begin
      x1_r <= x1_nxt;
      x2_r <= x2_nxt;
      y1_r <= y1_nxt;
      y2_r <= y2_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    acc_r  <= acc_nxt;
    if (ctl.load_in) begin
      x_r <= sample_in;
    end
    if (ctl.xs_ld) begin
      xs_r <= bq_pkg::round_sat(bq_pkg::ACC_W'(prod_r));
    end
    if (ctl.y_ld) begin
      out_r <= y_new;
    end
  end

  assign sample_out = out_r;

endmodule

`default_nettype wire

[src/biquad_iir_filter.sv]
// top level of the direct form I biquad filter with microcoded control
// Biquad IIR filter, direct form I, coefficients and gain in signed Q4.14.
// Each item's sample is scaled by the gain, rounded and saturated, then
// y = b0*x + b1*x1 + b2*x2 - a1*y1 - a2*y2 is summed at full width, rounded
// half up, shifted by 14 and saturated to 24 bits. One multiplier is shared
// by all six products under a ten-word microcode program (idle step plus
// nine work steps); an item is accepted only at the idle step. The finished
// sample sits in an output register, so the next item is taken while it
// waits; a new result only stalls if the previous one is still not taken.
// Setting clear_history zeroes the stored history before that item is
// filtered. Coefficients are written through cfg_we/cfg_index/cfg_wdata;
// the user must write them only while the block is idle, as the block
// itself does not enforce this; an index past the gain register is ignored.
`timescale 1ns / 1ps
`default_nettype none
`include "biquad_iir_filter_assert.svh"

module biquad_iir_filter (
  input  wire                                     clk,
  input  wire                                     rst_n,
  // input item channel
  input  wire                                     in_valid,
  output logic                                    in_ready,
  input  wire logic signed [bq_pkg::SAMPLE_W-1:0] in_sample_in,
  input  wire                                     in_clear_history,
  // result channel
  output logic                                    out_valid,
  input  wire                                     out_ready,
  output logic signed [bq_pkg::SAMPLE_W-1:0]      out_sample_out,
  // configuration write port
  input  wire                                     cfg_we,
  input  wire [bq_pkg::IDX_W-1:0]                 cfg_index,
  input  wire [bq_pkg::COEF_W-1:0]                cfg_wdata
);

  logic [bq_pkg::PC_W-1:0] pc_r, pc_nxt;
  logic                    out_valid_r, out_valid_nxt;
  bq_pkg::coef_set_t       coef_r, coef_nxt;
  bq_pkg::ucode_t          uw;
  bq_pkg::dp_ctl_t         dp_ctl;
  logic                    in_take;
  logic                    out_busy;

  // current control word straight from the rom
  assign uw       = bq_pkg::ucode(pc_r);
  assign in_ready = (uw.jmp == bq_pkg::JMP_WAIT_IN);
  assign in_take  = in_valid && in_ready;
  // output register still holds an untaken item
  assign out_busy = out_valid_r && !out_ready;

  // sequencer: step counter with wait conditions
  always_comb begin
    case (uw.jmp)
      bq_pkg::JMP_WAIT_IN: pc_nxt = in_take ? pc_r + bq_pkg::PC_W'(1) : pc_r;
      bq_pkg::JMP_DONE:    pc_nxt = out_busy ? pc_r : bq_pkg::STEP_IDLE;
      default:             pc_nxt = pc_r + bq_pkg::PC_W'(1);
    endcase
  end

  // datapath controls; result load is held back while the output is occupied
  always_comb begin
    dp_ctl.load_in    = in_take;
    dp_ctl.clear_hist = in_clear_history;
    dp_ctl.term       = uw.term;
    dp_ctl.acc_op     = uw.acc_op;
    dp_ctl.xs_ld      = uw.xs_ld;
    dp_ctl.y_ld       = uw.y_ld && !out_busy;
  end

  always_comb begin
    out_valid_nxt = out_valid_r && !out_ready;
    if (dp_ctl.y_ld) begin
      out_valid_nxt = 1'b1;
    end
  end

  // coefficient registers
  always_comb begin
    coef_nxt = coef_r;
    if (cfg_we) begin
      case (cfg_index)
        bq_pkg::REG_B0:   coef_nxt.b0   = cfg_wdata;
        bq_pkg::REG_B1:   coef_nxt.b1   = cfg_wdata;
        bq_pkg::REG_B2:   coef_nxt.b2   = cfg_wdata;
        bq_pkg::REG_A1:   coef_nxt.a1   = cfg_wdata;
        bq_pkg::REG_A2:   coef_nxt.a2   = cfg_wdata;
        bq_pkg::REG_GAIN: coef_nxt.gain = cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r        <= bq_pkg::STEP_IDLE;
      out_valid_r <= 1'b0;
      coef_r      <= '{b0: bq_pkg::COEF_ONE, b1: bq_pkg::COEF_ZERO,
                       b2: bq_pkg::COEF_ZERO, a1: bq_pkg::COEF_ZERO,
                       a2: bq_pkg::COEF_ZERO, gain: bq_pkg::COEF_ONE};
    end else begin
      pc_r        <= pc_nxt;
      out_valid_r <= out_valid_nxt;
      coef_r      <= coef_nxt;
    end
  end

  bq_datapath u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (dp_ctl),
    .coefs      (coef_r),
    .sample_in  (in_sample_in),
    .sample_out (out_sample_out)
  );

  assign out_valid = out_valid_r;

  // an accepted item always starts at the first work step
  `BQ_ASSERT_NEXT(a_accept_starts, in_take, pc_r == bq_pkg::STEP_FIRST)
  // the program counter never leaves the program
  `BQ_ASSERT_SAME(a_pc_in_range, 1'b1, pc_r <= bq_pkg::STEP_LAST)
  // a posted result shows up as a valid output in the next cycle
  `BQ_ASSERT_NEXT(a_result_posted, dp_ctl.y_ld, out_valid_r)
  // the final step waits while the output register is occupied
  `BQ_ASSERT_NEXT(a_done_holds, uw.jmp == bq_pkg::JMP_DONE && out_busy,
                  pc_r == bq_pkg::STEP_LAST && !in_ready)

endmodule

`default_nettype wire

[verif/testbench.sv]
// self-checking testbench for the direct form i biquad filter
`timescale 1ns / 1ps

module testbench;
  import bq_pkg::*;

  // a little margin when settling or finishing
  localparam int SETTLE_CYCLES = 12;
  localparam int TAIL_CYCLES   = 24;
  // no handshake for this long means the block is stuck
  localparam int QUIET_LIMIT   = 4000;
  localparam int IDLE_PCT      = 23;
  localparam int RAND_PHASES   = 8;
  localparam int PHASE_ITEMS   = 119;
  localparam int SHOW_MAX      = 10;

  // indexes past the gain register, writes there must be dropped
  localparam logic [IDX_W-1:0] REG_SPARE_LO = IDX_W'(6);
  localparam logic [IDX_W-1:0] REG_SPARE_HI = IDX_W'(7);

  localparam logic signed [COEF_W-1:0] COEF_MAX = {1'b0, {(COEF_W-1){1'b1}}};
  localparam logic signed [COEF_W-1:0] COEF_MIN = {1'b1, {(COEF_W-1){1'b0}}};

  // flavors of coefficient set for the random phases
  typedef enum logic [1:0] {
    SET_STABLE,
    SET_WILD,
    SET_EXTREME
  } coef_mix_t;

  typedef struct {
    logic signed [SAMPLE_W-1:0] smp;
    logic                       clr;
  } audio_item_t;

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       in_valid = 1'b0;
  logic                       in_ready;
  logic signed [SAMPLE_W-1:0] in_sample_in = '0;
  logic                       in_clear_history = 1'b0;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  logic signed [SAMPLE_W-1:0] out_sample_out;
  logic                       cfg_we = 1'b0;
  logic [IDX_W-1:0]           cfg_index = '0;
  logic [COEF_W-1:0]          cfg_wdata = '0;

  // samples waiting to be offered, filtered samples waiting to come out
  audio_item_t                pending_q[$];
  logic signed [SAMPLE_W-1:0] filtered_q[$];

  // shadow coefficient set and filter history
  longint gain_q = longint'(COEF_ONE);
  longint b0_q = longint'(COEF_ONE);
  longint b1_q = 0;
  longint b2_q = 0;
  longint a1_q = 0;
  longint a2_q = 0;
  longint x1_h = 0;
  longint x2_h = 0;
  longint y1_h = 0;
  longint y2_h = 0;

  // when set, neither side idles
  logic steady = 1'b0;

  int fail_cnt = 0;
  int items_taken = 0;
  int results_seen = 0;
  int clears_taken = 0;
  int settings_cnt = 1;
  int quiet_cycles = 0;

  biquad_iir_filter dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_sample_in     (in_sample_in),
    .in_clear_history (in_clear_history),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_sample_out   (out_sample_out),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // round half toward +inf, drop the q14 fraction, clamp to 24 bits
  function automatic longint round_clamp(input longint acc);
    longint r;
    r = (acc + (longint'(1) << (FRAC_BITS - 1))) >>> FRAC_BITS;
    if (r > longint'(SAT_MAX)) begin
      r = longint'(SAT_MAX);
    end else if (r < longint'(SAT_MIN)) begin
      r = longint'(SAT_MIN);
    end
    return r;
  endfunction

  // one step of the filter: gain, then the five-tap sum, history updated
  function automatic logic signed [SAMPLE_W-1:0] biquad_step(
    input logic signed [SAMPLE_W-1:0] smp,
    input logic                       clr
  );
    longint xs;
    longint acc;
    longint y;
    // a clear applies to the very item that carries it
    if (clr) begin
      x1_h = 0;
      x2_h = 0;
      y1_h = 0;
      y2_h = 0;
    end
    xs  = round_clamp(gain_q * longint'(smp));
    acc = b0_q * xs + b1_q * x1_h + b2_q * x2_h - a1_q * y1_h - a2_q * y2_h;
    y   = round_clamp(acc);
    // saturated values are the ones kept as history
    x2_h = x1_h;
    x1_h = xs;
    y2_h = y1_h;
    y1_h = y;
    return SAMPLE_W'(y);
  endfunction

  function automatic logic signed [COEF_W-1:0] pick_coef(input coef_mix_t mix);
    int lim;
    case (mix)
      SET_STABLE:  return COEF_W'(int'($urandom_range(0, 32768)) - 16384);
      SET_WILD:    return COEF_W'($urandom);
      default: begin
        lim = $urandom_range(0, 6);
        case (lim)
          0:       return COEF_MAX;
          1:       return COEF_MIN;
          2:       return COEF_ZERO;
          3:       return COEF_ONE;
          4:       return -COEF_ONE;
          5:       return COEF_W'(1);
          default: return COEF_W'(-1);
        endcase
      end
    endcase
  endfunction

  // mostly full-scale noise and quiet signal, some rail hits
  function automatic logic signed [SAMPLE_W-1:0] pick_sample();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) begin
      return SAMPLE_W'($urandom);
    end else if (r < 80) begin
      return SAMPLE_W'(int'($urandom_range(0, 65535)) - 32768);
    end else if (r < 90) begin
      r = $urandom_range(0, 3);
      case (r)
        0:       return SAT_MAX;
        1:       return SAT_MIN;
        2:       return '0;
        default: return '1;
      endcase
    end
    return SAMPLE_W'(int'($urandom_range(0, 1 << 20)) - (1 << 19));
  endfunction

  task automatic note_failure(input string msg);
    fail_cnt++;
    if (fail_cnt <= SHOW_MAX) begin
      $display("%s", msg);
    end
  endtask

  // register write, mirrored into the shadow set right away (block is idle)
  task automatic write_coef(input logic [IDX_W-1:0] idx, input logic [COEF_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      REG_B0:   b0_q = longint'($signed(val));
      REG_B1:   b1_q = longint'($signed(val));
      REG_B2:   b2_q = longint'($signed(val));
      REG_A1:   a1_q = longint'($signed(val));
      REG_A2:   a2_q = longint'($signed(val));
      REG_GAIN: gain_q = longint'($signed(val));
      default: ;
    endcase
  endtask

  task automatic close_writes();
    @(posedge clk);
    cfg_we <= 1'b0;
    settings_cnt++;
    @(negedge clk);
  endtask

  task automatic push_item(input logic signed [SAMPLE_W-1:0] smp, input logic clr);
    audio_item_t it;
    it.smp = smp;
    it.clr = clr;
    pending_q.push_back(it);
  endtask

  // sampled at the falling edge so driver and monitor updates have settled
  task automatic wait_drained();
    do begin
      @(negedge clk);
    end while (pending_q.size() != 0 || in_valid || filtered_q.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // driver: offer the next item once the current one is taken or none is up
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        filtered_q.push_back(biquad_step(in_sample_in, in_clear_history));
        items_taken++;
        if (in_clear_history) begin
          clears_taken++;
        end
      end
      if (!in_valid || in_ready) begin
        if (pending_q.size() != 0 && (steady || $urandom_range(0, 99) >= IDLE_PCT)) begin
          in_valid         <= 1'b1;
          in_sample_in     <= pending_q[0].smp;
          in_clear_history <= pending_q[0].clr;
          void'(pending_q.pop_front());
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: random back-pressure, every taken result checked in order
  always @(posedge clk) begin
    logic signed [SAMPLE_W-1:0] want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (filtered_q.size() == 0) begin
          note_failure($sformatf("result %0d: unexpected, got %0d",
                                 results_seen, out_sample_out));
        end else begin
          want = filtered_q.pop_front();
          if (out_sample_out !== want) begin
            note_failure($sformatf("result %0d: sample_out expected %0d, got %0d",
                                   results_seen, want, out_sample_out));
          end
        end
      end
      out_ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  // watchdog: any handshake or register write counts as progress
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("watchdog: no handshake for %0d cycles, %0d results still due",
                 QUIET_LIMIT, filtered_q.size());
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  initial begin
    int lim;
    int a2v;
    int p;
    int k;
    coef_mix_t mix;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset coefficients: unity gain, b0 = 1, so samples pass straight through
    push_item(SAT_MAX, 1'b0);
    push_item(SAT_MIN, 1'b0);
    push_item('0, 1'b0);
    push_item('1, 1'b0);
    push_item(SAMPLE_W'(1), 1'b1);
    push_item(SAMPLE_W'(4660), 1'b0);
    wait_drained();

    // every register at an extreme: scaled input and output both saturate
    write_coef(REG_GAIN, COEF_MAX);
    write_coef(REG_B0, COEF_MIN);
    write_coef(REG_B1, COEF_MAX);
    write_coef(REG_B2, COEF_MIN);
    write_coef(REG_A1, COEF_MAX);
    write_coef(REG_A2, COEF_MIN);
    close_writes();
    push_item(SAT_MAX, 1'b1);
    push_item(SAT_MIN, 1'b0);
    push_item(SAMPLE_W'(1), 1'b0);
    push_item('1, 1'b0);
    push_item('0, 1'b0);
    push_item(SAMPLE_W'(2), 1'b1);
    push_item(SAMPLE_W'(-2), 1'b0);
    wait_drained();

    // half gain exposes rounding ties; spare indexes must leave the set alone
    write_coef(REG_GAIN, COEF_W'(8192));
    write_coef(REG_B0, COEF_ONE);
    write_coef(REG_B1, COEF_ZERO);
    write_coef(REG_B2, COEF_ZERO);
    write_coef(REG_A1, COEF_ZERO);
    write_coef(REG_A2, COEF_ZERO);
    write_coef(REG_SPARE_LO, COEF_MAX);
    write_coef(REG_SPARE_HI, COEF_MIN);
    close_writes();
    push_item(SAMPLE_W'(1), 1'b1);
    push_item(SAMPLE_W'(-1), 1'b0);
    push_item(SAMPLE_W'(3), 1'b0);
    push_item(SAMPLE_W'(-3), 1'b0);
    push_item(SAT_MAX, 1'b0);
    push_item(SAT_MIN, 1'b0);
    wait_drained();

    // resonant low-pass: impulse ring-down, then a clear mid-ring
    write_coef(REG_GAIN, COEF_ONE);
    write_coef(REG_B0, COEF_W'(4096));
    write_coef(REG_B1, COEF_W'(8192));
    write_coef(REG_B2, COEF_W'(4096));
    write_coef(REG_A1, COEF_W'(-26000));
    write_coef(REG_A2, COEF_W'(12000));
    close_writes();
    push_item(SAMPLE_W'(1000000), 1'b1);
    push_item('0, 1'b0);
    push_item('0, 1'b0);
    push_item('0, 1'b0);
    push_item('0, 1'b1);
    wait_drained();

    // random phases: half with stable filters, the rest with wild or railed sets
    for (p = 0; p < RAND_PHASES; p++) begin
      mix = (p % 4 == 1) ? SET_WILD : (p % 4 == 3) ? SET_EXTREME : SET_STABLE;
      if (mix == SET_STABLE) begin
        // poles inside the unit circle: |a2| < 1, |a1| < 1 + a2
        a2v = int'($urandom_range(0, 31000)) - 15500;
        lim = 16384 + a2v - 200;
        write_coef(REG_GAIN, COEF_W'($urandom_range(4096, 32768)));
        write_coef(REG_A1, COEF_W'(int'($urandom_range(0, 2 * lim)) - lim));
        write_coef(REG_A2, COEF_W'(a2v));
      end else begin
        write_coef(REG_GAIN, pick_coef(mix));
        write_coef(REG_A1, pick_coef(mix));
        write_coef(REG_A2, pick_coef(mix));
      end
      write_coef(REG_B0, pick_coef(mix));
      write_coef(REG_B1, pick_coef(mix));
      write_coef(REG_B2, pick_coef(mix));
      if ($urandom_range(0, 1) == 1) begin
        write_coef($urandom_range(0, 1) ? REG_SPARE_HI : REG_SPARE_LO, COEF_W'($urandom));
      end
      close_writes();
      // one stable phase runs with both sides always ready
      steady = (p == 2);
      for (k = 0; k < PHASE_ITEMS; k++) begin
        push_item(pick_sample(), $urandom_range(0, 99) < 3);
      end
      wait_drained();
      steady = 1'b0;
    end

    repeat (TAIL_CYCLES) @(negedge clk);
    if (filtered_q.size() != 0) begin
      note_failure($sformatf("%0d results never came out", filtered_q.size()));
    end
    $display("filtered %0d samples (%0d with history clear) across %0d coefficient sets",
             items_taken, clears_taken, settings_cnt);
    $display("checked %0d results, %0d failures", results_seen, fail_cnt);
    if (fail_cnt == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+src
src/bq_pkg.sv
src/bq_datapath.sv
src/biquad_iir_filter.sv
verif/testbench.sv
